// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files of the cache model.
// No dependencies; each file that asserts includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/sacl_pkg.sv =====
// Package of the set-associative LRU cache model: field widths, codes and reset values.
// No dependencies; imported by the top level.
`default_nettype none

package sacl_pkg;

  localparam int ADDR_W = 64;
  localparam int TAG_W  = 62;   // tag is at most 64 - 2 bits wide
  localparam int REQ_W  = 2;
  localparam int CNT_W  = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int SETB_W     = 3;
  localparam int WAYS_W     = 4;
  localparam int OFFB_W     = 6;
  localparam int SEFF_W     = 4;  // clamped set bit count, up to 7
  localparam int SHIFT_W    = 7;  // offset plus set bits, up to 39

  localparam logic [OFFB_W-1:0] OFFB_MAX = 6'd32;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OFF_BITS = 2'd2;

  localparam logic [SETB_W-1:0] SETB_RST = 3'd1;
  localparam logic [WAYS_W-1:0] WAYS_RST = 4'd1;
  localparam logic [OFFB_W-1:0] OFFB_RST = 6'd4;

  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STORE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_MODIFY = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/sacl_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies; used by the cache top level for the set rows.
`default_nettype none

module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/set_assoc_lru_cache_sim_unit.sv =====
// Top level of the set-associative cache model with LRU replacement.
// Depends on sacl_pkg, sacl_ram and assert_macros.svh.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------------------
//   in      | input     | in_valid_i / in_ready_o  | req_type_i, address_i
//   out     | output    | out_valid_o / out_ready_i| hits_this_item_o, missed_o, evicted_o,
//           |           |                          | total_hits_o, total_misses_o,
//           |           |                          | total_evictions_o
//   cfg     | input     | cfg_we_i (no wait)       | cfg_idx_i, cfg_wdata_i
//
// A load or store goes through decode, read, load, a walk of n ways (1 to ways_in_use)
// by the single tag comparator to a hit or the set's end, write-back and result; a modify
// adds a second walk and write-back; a none request goes straight to the result. After
// reset a clearing pass zeroes one set row per cycle, all 2**MAX_SET_BITS rows (64 by default),
// taking configuration but no word. A finished result waits in the output register while the
// next word is accepted; the block stalls only when a second result is ready before that.
`default_nettype none

`include "assert_macros.svh"

module set_assoc_lru_cache_sim_unit #(
  parameter int MAX_SET_BITS = 6,
  parameter int MAX_WAYS     = 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,

  input  wire logic                              in_valid_i,
  output      logic                              in_ready_o,
  input  wire logic [sacl_pkg::REQ_W-1:0]        req_type_i,
  input  wire logic [sacl_pkg::ADDR_W-1:0]       address_i,

  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic [1:0]                        hits_this_item_o,
  output      logic                              missed_o,
  output      logic                              evicted_o,
  output      logic [sacl_pkg::CNT_W-1:0]        total_hits_o,
  output      logic [sacl_pkg::CNT_W-1:0]        total_misses_o,
  output      logic [sacl_pkg::CNT_W-1:0]        total_evictions_o,

  input  wire logic                              cfg_we_i,
  input  wire logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  import sacl_pkg::*;

  localparam int NUM_SETS = 2 ** MAX_SET_BITS;
  localparam int SET_W    = MAX_SET_BITS;
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int RANK_W   = WAY_W;
  localparam int WCNT_W   = $clog2(MAX_WAYS + 1);

  localparam logic [RANK_W-1:0] RANK_TOP = RANK_W'(MAX_WAYS - 1);

  // Sequencer states.
  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_DECODE = 3'd2;
  localparam logic [2:0] ST_READ   = 3'd3;
  localparam logic [2:0] ST_LOAD   = 3'd4;
  localparam logic [2:0] ST_SCAN   = 3'd5;
  localparam logic [2:0] ST_UPDATE = 3'd6;
  localparam logic [2:0] ST_RESULT = 3'd7;

  // One way of a set row; rank 0 is the most recently used line.
  typedef struct packed {
    logic              vld;
    logic [TAG_W-1:0]  tag;
    logic [RANK_W-1:0] rank;
  } entry_t;

  typedef entry_t [MAX_WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  // Control state.
  logic [2:0]        state_q;
  logic [SET_W-1:0]  clr_cnt_q;
  logic [WAY_W-1:0]  way_q;
  logic              hit_q;
  logic              free_q;
  logic              second_q;
  logic              out_valid_q;
  logic [SETB_W-1:0] set_bits_q;
  logic [WAYS_W-1:0] ways_q;
  logic [OFFB_W-1:0] off_bits_q;
  logic [CNT_W-1:0]  hit_cnt_q;
  logic [CNT_W-1:0]  miss_cnt_q;
  logic [CNT_W-1:0]  evict_cnt_q;

  // Payload and scan bookkeeping.
  logic [REQ_W-1:0]  req_q;
  logic [ADDR_W-1:0] addr_q;
  logic [TAG_W-1:0]  tag_q;
  logic [SET_W-1:0]  set_q;
  row_t              row_q;
  logic [WAY_W-1:0]  hit_way_q;
  logic [WAY_W-1:0]  free_way_q;
  logic [WAY_W-1:0]  victim_q;
  logic [RANK_W-1:0] oldest_q;
  logic [1:0]        item_hits_q;
  logic              item_missed_q;
  logic              item_evicted_q;
  logic [1:0]        out_hits_q;
  logic              out_missed_q;
  logic              out_evicted_q;
  logic [CNT_W-1:0]  out_tot_hits_q;
  logic [CNT_W-1:0]  out_tot_misses_q;
  logic [CNT_W-1:0]  out_tot_evict_q;

  // Combinational signals.
  logic [SEFF_W-1:0]  s_eff;
  logic [OFFB_W-1:0]  b_eff;
  logic [WCNT_W-1:0]  ways_eff;
  logic [WAY_W-1:0]   last_way;
  logic [SHIFT_W-1:0] tag_shift;
  logic [SET_W-1:0]   set_mask;
  logic [TAG_W-1:0]   tag_calc;
  logic [SET_W-1:0]   set_calc;
  entry_t             cur_ent;
  logic               cur_match;
  logic [WAY_W-1:0]   tgt_way;
  logic [RANK_W-1:0]  limit_rank;
  logic               use_limit;
  row_t               row_new;
  logic               ram_we;
  logic [SET_W-1:0]   ram_waddr;
  logic [ROW_W-1:0]   ram_wdata;
  logic [ROW_W-1:0]   ram_rdata;
  logic               accept_in;
  logic               result_load;

  // Clamp the configuration into its legal ranges.
  always_comb begin
    if (set_bits_q == '0) begin
      s_eff = SEFF_W'(1);
    end else if (SEFF_W'(set_bits_q) > SEFF_W'(MAX_SET_BITS)) begin
      s_eff = SEFF_W'(MAX_SET_BITS);
    end else begin
      s_eff = SEFF_W'(set_bits_q);
    end

    if (off_bits_q == '0) begin
      b_eff = OFFB_W'(1);
    end else if (off_bits_q > OFFB_MAX) begin
      b_eff = OFFB_MAX;
    end else begin
      b_eff = off_bits_q;
    end

    if (ways_q == '0) begin
      ways_eff = WCNT_W'(1);
    end else if (5'(ways_q) > 5'(MAX_WAYS)) begin
      ways_eff = WCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WCNT_W'(ways_q);
    end
  end

  assign last_way = WAY_W'(ways_eff - WCNT_W'(1));

  // Address split: offset, then set index, then the tag in the remaining high bits.
  always_comb begin
    for (int i = 0; i < SET_W; i++) begin
      set_mask[i] = (i < int'(s_eff));
    end
  end

  assign tag_shift = SHIFT_W'(b_eff) + SHIFT_W'(s_eff);
  assign tag_calc  = TAG_W'(addr_q >> tag_shift);
  assign set_calc  = SET_W'(addr_q >> b_eff) & set_mask;

  // The shared tag comparator looks at one way per cycle.
  assign cur_ent   = row_q[way_q];
  assign cur_match = cur_ent.vld && (cur_ent.tag == tag_q);

  // Row update after a walk. A hit ages the ways younger than the hit line, a fill into a
  // free way ages every valid way, and an eviction ages the ways younger than the victim.
  always_comb begin
    if (hit_q) begin
      tgt_way = hit_way_q;
    end else if (free_q) begin
      tgt_way = free_way_q;
    end else begin
      tgt_way = victim_q;
    end
    use_limit  = hit_q || !free_q;
    limit_rank = row_q[tgt_way].rank;

    for (int w = 0; w < MAX_WAYS; w++) begin
      row_new[w] = row_q[w];
      if ((WCNT_W'(w) < ways_eff) && row_q[w].vld && (row_q[w].rank < RANK_TOP) &&
          (!use_limit || (row_q[w].rank < limit_rank))) begin
        row_new[w].rank = row_q[w].rank + RANK_W'(1);
      end
      if (WAY_W'(w) == tgt_way) begin
        row_new[w].vld  = 1'b1;
        row_new[w].tag  = tag_q;
        row_new[w].rank = '0;
      end
    end
  end

  // The clearing pass and the write-back of an updated row share the one write port.
  assign ram_we    = (state_q == ST_CLEAR) || (state_q == ST_UPDATE);
  assign ram_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : set_q;
  assign ram_wdata = (state_q == ST_CLEAR) ? '0 : ROW_W'(row_new);

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (set_q),
    .rdata_o (ram_rdata)
  );

  assign accept_in   = in_valid_i && in_ready_o;
  assign result_load = (state_q == ST_RESULT) && (!out_valid_q || out_ready_i);

  // Sequencer, configuration and running counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      way_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
      set_bits_q  <= SETB_RST;
      ways_q      <= WAYS_RST;
      off_bits_q  <= OFFB_RST;
      hit_cnt_q   <= '0;
      miss_cnt_q  <= '0;
      evict_cnt_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SET_BITS: set_bits_q <= cfg_wdata_i[SETB_W-1:0];
          CFG_WAYS:     ways_q     <= cfg_wdata_i[WAYS_W-1:0];
          CFG_OFF_BITS: off_bits_q <= cfg_wdata_i[OFFB_W-1:0];
          default: ;
        endcase
      end

      if (result_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        ST_CLEAR: begin
          clr_cnt_q <= clr_cnt_q + SET_W'(1);
          if (clr_cnt_q == '1) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept_in) begin
            second_q <= 1'b0;
            state_q  <= (req_type_i == REQ_NONE) ? ST_RESULT : ST_DECODE;
          end
        end
        ST_DECODE: begin
          state_q <= ST_READ;
        end
        ST_READ: begin
          state_q <= ST_LOAD;
        end
        ST_LOAD: begin
          way_q   <= '0;
          hit_q   <= 1'b0;
          free_q  <= 1'b0;
          state_q <= ST_SCAN;
        end
        ST_SCAN: begin
          if (cur_match) begin
            hit_q   <= 1'b1;
            state_q <= ST_UPDATE;
          end else begin
            if (!cur_ent.vld) begin
              free_q <= 1'b1;
            end
            if (way_q == last_way) begin
              state_q <= ST_UPDATE;
            end else begin
              way_q <= way_q + WAY_W'(1);
            end
          end
        end
        ST_UPDATE: begin
          if (hit_q) begin
            hit_cnt_q <= hit_cnt_q + CNT_W'(hit_cnt_q != '1);
          end else begin
            miss_cnt_q <= miss_cnt_q + CNT_W'(miss_cnt_q != '1);
            if (!free_q) begin
              evict_cnt_q <= evict_cnt_q + CNT_W'(evict_cnt_q != '1);
            end
          end
          if ((req_q == REQ_MODIFY) && !second_q) begin
            // The second access of a modify walks the row just written back.
            second_q <= 1'b1;
            way_q    <= '0;
            hit_q    <= 1'b0;
            free_q   <= 1'b0;
            state_q  <= ST_SCAN;
          end else begin
            state_q <= ST_RESULT;
          end
        end
        ST_RESULT: begin
          if (result_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers and scan bookkeeping.
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      req_q          <= req_type_i;
      addr_q         <= address_i;
      item_hits_q    <= '0;
      item_missed_q  <= 1'b0;
      item_evicted_q <= 1'b0;
    end

    if (state_q == ST_DECODE) begin
      tag_q <= tag_calc;
      set_q <= set_calc;
    end

    if (state_q == ST_LOAD) begin
      row_q <= row_t'(ram_rdata);
    end

    if (state_q == ST_SCAN) begin
      if (cur_match) begin
        hit_way_q <= way_q;
      end
      if (!cur_ent.vld && !free_q) begin
        free_way_q <= way_q;
      end
      if ((way_q == '0) || (cur_ent.rank > oldest_q)) begin
        oldest_q <= cur_ent.rank;
        victim_q <= way_q;
      end
    end

    if (state_q == ST_UPDATE) begin
      row_q       <= row_new;
      item_hits_q <= item_hits_q + {1'b0, hit_q};
      if (!second_q) begin
        item_missed_q <= !hit_q;
      end
      if (!hit_q && !free_q) begin
        item_evicted_q <= 1'b1;
      end
    end

    if (result_load) begin
      out_hits_q       <= item_hits_q;
      out_missed_q     <= item_missed_q;
      out_evicted_q    <= item_evicted_q;
      out_tot_hits_q   <= hit_cnt_q;
      out_tot_misses_q <= miss_cnt_q;
      out_tot_evict_q  <= evict_cnt_q;
    end
  end

  assign in_ready_o        = (state_q == ST_IDLE);
  assign out_valid_o       = out_valid_q;
  assign hits_this_item_o  = out_hits_q;
  assign missed_o          = out_missed_q;
  assign evicted_o         = out_evicted_q;
  assign total_hits_o      = out_tot_hits_q;
  assign total_misses_o    = out_tot_misses_q;
  assign total_evictions_o = out_tot_evict_q;

  // A word whose first access missed can hit at most once, on its second access.
  `ASSERT_IMPL(a_miss_limits_hits, clk_i, rst_ni, out_valid_o && missed_o, hits_this_item_o < 2'd2)
  // A reported miss or eviction is already reflected in the running totals.
  `ASSERT_IMPL(a_miss_counted, clk_i, rst_ni, out_valid_o && missed_o, total_misses_o != '0)
  `ASSERT_IMPL(a_evict_counted, clk_i, rst_ni, out_valid_o && evicted_o, total_evictions_o != '0)
  // The saturating hit counter never goes backward.
  `ASSERT_NEXT(a_hits_monotonic, clk_i, rst_ni, 1'b1, hit_cnt_q >= $past(hit_cnt_q))

endmodule

`default_nettype wire
